/* hw/rtl/pbc_pkg.sv */
package pbc_pkg;

  // Cache geometry.
  localparam int SLOTS      = 16;
  localparam int BLOCK_BITS = 20;
  localparam int PIN_BITS   = 8;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int COUNT_W = $clog2(SLOTS + 1);
  localparam int STAMP_W = 32;

  // Configuration register widths.
  localparam int MAXRES_W = 5;
  localparam int BSIZE_W  = 21;
  localparam int BACK_W   = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Length arithmetic widths.
  localparam int PROD_W = BLOCK_BITS + BSIZE_W;
  localparam int EXT_W  = (PROD_W > BACK_W) ? PROD_W : BACK_W;
  localparam int LEN_W  = BSIZE_W;

  localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RESIDENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKING_SIZE = 2'd2;

  // Request commands.
  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  // Result status codes.
  localparam logic [2:0] STAT_OK           = 3'd0;
  localparam logic [2:0] STAT_NOT_RESIDENT = 3'd1;
  localparam logic [2:0] STAT_NOT_PINNED   = 3'd2;
  localparam logic [2:0] STAT_NO_SLOT      = 3'd3;
  localparam logic [2:0] STAT_PIN_OVERFLOW = 3'd4;

  typedef struct packed {
    logic                  command;
    logic [BLOCK_BITS-1:0] block_number;
  } pbc_in_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_W-1:0]     slot;
    logic                  fetch_needed;
    logic [LEN_W-1:0]      valid_length;
    logic                  evicted_valid;
    logic [BLOCK_BITS-1:0] evicted_block;
    logic [2:0]            status;
  } pbc_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_DECIDE,
    S_SCAN,
    S_EVICT,
    S_ALLOC,
    S_LEN,
    S_DONE
  } pbc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic search;
    logic lock_hit;
    logic pin_ovf;
    logic not_resident;
    logic not_pinned;
    logic unlock_dec;
    logic scan_step;
    logic evict;
    logic alloc;
    logic len_calc;
    logic out_load;
  } pbc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_unlock;
    logic matched;
    logic pins_full;
    logic pins_zero;
    logic pins_one;
    logic at_limit;
    logic over_limit;
    logic scan_last;
    logic out_busy;
  } pbc_stat_t;

endpackage

/* hw/rtl/pbc_ctrl.sv */
module pbc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pbc_pkg::pbc_stat_t stat,
  output pbc_pkg::pbc_cmd_t  cmd,
  output logic              in_stall
);
  import pbc_pkg::*;

  pbc_state_t state_r;
  pbc_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SEARCH;
      end
      S_SEARCH: state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (!stat.is_unlock) begin
          if (stat.matched) begin
            state_nxt = stat.pins_full ? S_DONE : S_LEN;
          end else begin
            state_nxt = stat.at_limit ? S_SCAN : S_ALLOC;
          end
        end else begin
          if (stat.matched && stat.pins_one && stat.over_limit) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (stat.scan_last) state_nxt = S_EVICT;
      end
      S_EVICT: state_nxt = stat.is_unlock ? S_DONE : S_ALLOC;
      S_ALLOC: state_nxt = S_LEN;
      S_LEN:   state_nxt = S_DONE;
      S_DONE: begin
        if (!stat.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command decode.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      S_SEARCH: cmd.search = 1'b1;
      S_DECIDE: begin
        if (!stat.is_unlock) begin
          cmd.lock_hit = stat.matched && !stat.pins_full;
          cmd.pin_ovf  = stat.matched && stat.pins_full;
        end else begin
          cmd.not_resident = !stat.matched;
          cmd.not_pinned   = stat.matched && stat.pins_zero;
          cmd.unlock_dec   = stat.matched && !stat.pins_zero;
        end
      end
      S_SCAN:  cmd.scan_step = 1'b1;
      S_EVICT: cmd.evict     = 1'b1;
      S_ALLOC: cmd.alloc     = 1'b1;
      S_LEN:   cmd.len_calc  = 1'b1;
      S_DONE:  cmd.out_load  = !stat.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

/* hw/rtl/pbc_dpath.sv */
module pbc_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pbc_pkg::pbc_cmd_t               cmd,
  output pbc_pkg::pbc_stat_t              stat,
  input  pbc_pkg::pbc_in_t                in_data,
  input  logic                            cfg_valid,
  input  logic [pbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pbc_pkg::pbc_out_t               out_data
);
  import pbc_pkg::*;

  // Configuration registers.
  logic [MAXRES_W-1:0] max_res_r;
  logic [BSIZE_W-1:0]  bsize_r;
  logic [BACK_W-1:0]   back_r;

  // Entry store.
  logic [SLOTS-1:0]    valid_r;
  logic [BLOCK_BITS-1:0] tag_r   [SLOTS];
  logic [PIN_BITS-1:0]   pins_r  [SLOTS];
  logic [STAMP_W-1:0]    stamp_r [SLOTS];
  logic [STAMP_W-1:0]    clock_r;
  logic [COUNT_W-1:0]    count_r;

  // Request and search registers.
  logic                  item_cmd_r;
  logic [BLOCK_BITS-1:0] item_tag_r;
  logic                  match_r;
  logic [SLOT_W-1:0]     match_slot_r;
  logic [PROD_W-1:0]     prod_r;

  // Eviction scan registers.
  logic [SLOT_W-1:0]  scan_idx_r;
  logic               best_v_r;
  logic [SLOT_W-1:0]  best_slot_r;
  logic [STAMP_W-1:0] best_stamp_r;

  // Result registers.
  logic                  res_hit_r;
  logic [SLOT_W-1:0]     res_slot_r;
  logic                  res_alloc_r;
  logic                  res_len_en_r;
  logic                  res_ev_v_r;
  logic [BLOCK_BITS-1:0] res_ev_b_r;
  logic [2:0]            res_status_r;
  logic                  past_r;
  logic [BACK_W-1:0]     rem_r;

  // Output register.
  logic     out_valid_r;
  pbc_out_t out_data_r;

  // Combinational helpers.
  logic [SLOTS-1:0]    hit_vec;
  logic                search_hit;
  logic [SLOT_W-1:0]   search_slot;
  logic [SLOTS-1:0]    cand;
  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;
  logic [PIN_BITS-1:0] cur_pins;
  logic [STAMP_W-1:0]  clock_inc;
  logic                scan_better;
  logic [EXT_W-1:0]    rem_full;
  logic [LEN_W-1:0]    len_val;

  // Configuration writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_res_r <= MAXRES_W'(16);
      bsize_r   <= BSIZE_W'(4096);
      back_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAX_RESIDENT: max_res_r <= cfg_data[MAXRES_W-1:0];
        CFG_BLOCK_SIZE:   bsize_r   <= cfg_data[BSIZE_W-1:0];
        CFG_BACKING_SIZE: back_r    <= cfg_data[BACK_W-1:0];
        default: ;
      endcase
    end
  end

  // Parallel tag compare, lowest matching slot wins.
  always_comb begin
    search_hit  = 1'b0;
    search_slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = valid_r[i] && (tag_r[i] == item_tag_r);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        search_hit  = 1'b1;
        search_slot = SLOT_W'(i);
      end
    end
  end

  // Eviction candidates and lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      cand[i] = valid_r[i] && (pins_r[i] == '0);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign cur_pins    = pins_r[match_slot_r];
  assign clock_inc   = clock_r + STAMP_W'(1);
  assign scan_better = cand[scan_idx_r] &&
                       (!best_v_r || (stamp_r[scan_idx_r] < best_stamp_r));

  // Status toward the controller.
  always_comb begin
    stat.is_unlock  = (item_cmd_r == CMD_UNLOCK);
    stat.matched    = match_r;
    stat.pins_full  = (cur_pins == PIN_MAX);
    stat.pins_zero  = (cur_pins == '0);
    stat.pins_one   = (cur_pins == PIN_BITS'(1));
    stat.at_limit   = (32'(count_r) >= 32'(max_res_r));
    stat.over_limit = (32'(count_r) > 32'(max_res_r));
    stat.scan_last  = (scan_idx_r == SLOT_W'(SLOTS - 1));
    stat.out_busy   = out_valid_r && out_stall;
  end

  // Entry payload writes.
  always_ff @(posedge clk) begin
    if (cmd.lock_hit) begin
      pins_r[match_slot_r]  <= cur_pins + PIN_BITS'(1);
      stamp_r[match_slot_r] <= clock_inc;
    end
    if (cmd.unlock_dec) begin
      pins_r[match_slot_r] <= cur_pins - PIN_BITS'(1);
    end
    if (cmd.alloc && free_found) begin
      tag_r[free_slot]   <= item_tag_r;
      pins_r[free_slot]  <= PIN_BITS'(1);
      stamp_r[free_slot] <= clock_inc;
    end
  end

  // Valid bits, use clock and resident count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      clock_r <= '0;
      count_r <= '0;
    end else begin
      if (cmd.lock_hit) begin
        clock_r <= clock_inc;
      end
      if (cmd.evict && best_v_r) begin
        valid_r[best_slot_r] <= 1'b0;
        if (count_r != '0) count_r <= count_r - COUNT_W'(1);
      end
      if (cmd.alloc && free_found) begin
        valid_r[free_slot] <= 1'b1;
        clock_r            <= clock_inc;
        count_r            <= count_r + COUNT_W'(1);
      end
    end
  end

  // Request capture, tag search and block offset product.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_cmd_r <= in_data.command;
      item_tag_r <= in_data.block_number;
    end
    if (cmd.search) begin
      match_r      <= search_hit;
      match_slot_r <= search_slot;
      prod_r       <= PROD_W'(item_tag_r) * PROD_W'(bsize_r);
    end
  end

  // Least-recent scan, one slot per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      scan_idx_r <= '0;
      best_v_r   <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + SLOT_W'(1);
      if (scan_better) begin
        best_v_r     <= 1'b1;
        best_slot_r  <= scan_idx_r;
        best_stamp_r <= stamp_r[scan_idx_r];
      end
    end
  end

  assign rem_full = EXT_W'(back_r) - EXT_W'(prod_r);

  // Result fields collected along the way.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res_hit_r    <= 1'b0;
      res_slot_r   <= '0;
      res_alloc_r  <= 1'b0;
      res_len_en_r <= 1'b0;
      res_ev_v_r   <= 1'b0;
      res_ev_b_r   <= '0;
      res_status_r <= STAT_OK;
    end
    if (cmd.lock_hit) begin
      res_hit_r    <= 1'b1;
      res_slot_r   <= match_slot_r;
      res_len_en_r <= 1'b1;
    end
    if (cmd.pin_ovf) begin
      res_hit_r    <= 1'b1;
      res_slot_r   <= match_slot_r;
      res_status_r <= STAT_PIN_OVERFLOW;
    end
    if (cmd.not_resident) begin
      res_status_r <= STAT_NOT_RESIDENT;
    end
    if (cmd.not_pinned) begin
      res_slot_r   <= match_slot_r;
      res_status_r <= STAT_NOT_PINNED;
    end
    if (cmd.unlock_dec) begin
      res_slot_r <= match_slot_r;
    end
    if (cmd.evict && best_v_r) begin
      res_ev_v_r <= 1'b1;
      res_ev_b_r <= tag_r[best_slot_r];
    end
    if (cmd.alloc) begin
      if (free_found) begin
        res_slot_r   <= free_slot;
        res_alloc_r  <= 1'b1;
        res_len_en_r <= 1'b1;
      end else begin
        res_status_r <= STAT_NO_SLOT;
      end
    end
    if (cmd.len_calc) begin
      past_r <= (EXT_W'(prod_r) >= EXT_W'(back_r));
      rem_r  <= rem_full[BACK_W-1:0];
    end
  end

  // Clamp the remaining bytes to one block.
  always_comb begin
    if (!res_len_en_r || past_r) begin
      len_val = '0;
    end else if (rem_r < BACK_W'(bsize_r)) begin
      len_val = rem_r[LEN_W-1:0];
    end else begin
      len_val = bsize_r;
    end
  end

  // Output register; a finished beat waits here while the next request runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.hit           <= res_hit_r;
      out_data_r.slot          <= res_slot_r;
      out_data_r.fetch_needed  <= res_alloc_r && (len_val != '0);
      out_data_r.valid_length  <= len_val;
      out_data_r.evicted_valid <= res_ev_v_r;
      out_data_r.evicted_block <= res_ev_b_r;
      out_data_r.status        <= res_status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/pinned_block_cache_policy.sv */
// Tag and replacement engine for a fully associative block cache of 16 slots
// with pin counts. Each lock or unlock request returns exactly one result beat.
// Requests are handled one at a time: a lock hit runs search, decide, length
// and done (no length step when its pin count is already full), an unlock
// search, decide and done, and a lock miss adds an allocation step before
// length; when an eviction is needed the least-recent search walks the slots
// one per cycle and an evict step follows. A finished result sits in the
// output register, so the next request is taken while it waits; that request
// holds in its last cycle until the waiting beat has been taken. The
// configuration port is always ready and must only be written while idle.
module pinned_block_cache_policy (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pbc_pkg::pbc_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output pbc_pkg::pbc_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pbc_pkg::*;

  pbc_cmd_t  cmd;
  pbc_stat_t stat;

  assign cfg_ready = 1'b1;

  pbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  pbc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* hw/rtl/pbc_checker.sv */
module pbc_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              out_valid,
  input  logic              out_stall,
  input  pbc_pkg::pbc_out_t out_data
);
  import pbc_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Requests are handled one at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another is in flight");

  // Failed requests report no length and no fetch.
  a_err_no_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != STAT_OK) |->
      !out_data.fetch_needed && (out_data.valid_length == '0))
    else $error("error result carries a length");

  // A fetch only follows a successful new allocation.
  a_fetch_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fetch_needed |->
      !out_data.hit && (out_data.status == STAT_OK))
    else $error("fetch without allocation");

  // The evicted block field is zero when nothing was evicted.
  a_evict_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.evicted_valid |-> (out_data.evicted_block == '0))
    else $error("stale evicted block");

endmodule

bind pinned_block_cache_policy pbc_checker u_pbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
